FILE: rtl/msprc_pkg.sv
// ---------------------------------------------------------------------------
// msprc_pkg
// Shared types and constants of the servo pulse ramp controller.
// ---------------------------------------------------------------------------
`default_nettype none
package msprc_pkg;

  localparam int unsigned Channels = 8;
  localparam int unsigned ChW      = 3;
  localparam int unsigned WidthW   = 12;
  localparam int unsigned TimeW    = 16;

  localparam logic [11:0] SlotUs     = 12'd2500;
  localparam logic [11:0] PulseMinUs = 12'd500;
  localparam logic [11:0] PulseMaxUs = 12'd2400;
  localparam logic [11:0] MapLowUs   = 12'd1000;
  localparam logic [9:0]  MapSpanUs  = 10'd1000;
  localparam logic [7:0]  PosFull    = 8'd255;

  localparam logic [1:0] OpSetPos  = 2'd0;
  localparam logic [1:0] OpSetUs   = 2'd1;
  localparam logic [1:0] OpTick    = 2'd2;
  localparam logic [1:0] OpSlotExp = 2'd3;

  localparam logic [2:0] RegCount   = 3'd0;
  localparam logic [2:0] RegLower   = 3'd1;
  localparam logic [2:0] RegUpper   = 3'd2;
  localparam logic [2:0] RegTimesLo = 3'd3;
  localparam logic [2:0] RegTimesHi = 3'd4;

  // Commands from controller to datapath.
  typedef struct packed {
    logic          load_item;  // latch input item
    logic          set_pos;    // start ramp from position
    logic          set_us;     // start ramp from microseconds
    logic          reload_ch;  // reload channel sel
    logic          tick_inc;   // increment all elapsed counters
    logic          ramp_load;  // load channel sel into ramp unit
    logic          ramp_step;  // advance serial multiply/divide
    logic          ramp_write; // write ramp result to channel sel
    logic          slot_emit;  // emit slot result
    logic [ChW-1:0] sel;
  } msprc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0]  op;
    logic        ramp_done;
    logic        ramp_skip;  // channel needs no division
    logic [3:0]  count;      // effective active count 1..8
  } msprc_sts_t;

  // Map a position to microseconds: 1000 + 1000*p/255.
  function automatic logic [11:0] pos_to_us(input logic [7:0] p);
    logic [17:0] prod;
    logic [17:0] q;
    logic [17:0] r;
    begin
      prod = 18'(p) * 18'(MapSpanUs);
      // divide by 255: the estimate is at most one below, so correct upward
      q = (prod + (prod >> 8) + 18'd1) >> 8;
      r = prod - 18'(q * 18'(PosFull));
      if (r >= 18'(PosFull)) begin
        q = q + 18'd1;
      end
      pos_to_us = MapLowUs + 12'(q);
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/msprc_datapath.sv
// ---------------------------------------------------------------------------
// msprc_datapath
// Channel state, configuration registers and serial ramp arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none
module msprc_datapath (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [1:0]              op_i,
  input  wire logic [2:0]              channel_i,
  input  wire logic [7:0]              position_i,
  input  wire logic [15:0]             pulse_us_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [2:0]              cfg_index_i,
  input  wire logic [63:0]             cfg_data_i,
  input  wire msprc_pkg::msprc_cmd_t   cmd_i,
  output msprc_pkg::msprc_sts_t        sts_o,
  output logic                         strobe_o,
  output logic [2:0]                   pin_channel_o,
  output logic                         pin_level_o,
  output logic [11:0]                  delay_us_o
);
  import msprc_pkg::*;

  logic [3:0]  count_reg_q;
  logic [63:0] lower_q, upper_q, tlo_q, thi_q;
  logic [WidthW-1:0] cur_q [Channels];
  logic [WidthW-1:0] tgt_q [Channels];
  logic [WidthW-1:0] st_q  [Channels];
  logic [TimeW-1:0]  el_q  [Channels];
  logic [ChW-1:0] slot_q;
  logic           phase_q;

  logic [1:0]  op_q;
  logic [2:0]  ch_q;
  logic [7:0]  pos_q;
  logic [15:0] us_q;

  // Ramp unit: serial multiply then restoring divide.
  logic [27:0] acc_q;      // product / remainder-quotient
  logic [15:0] mul_q;      // multiplier bits
  logic [15:0] div_q;      // divisor
  logic [12:0] mag_q;      // |diff|
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic        phase_div_q;
  logic        done_q;
  logic [16:0] rem_q;
  logic [27:0] quo_q;

  logic [3:0]  count_eff;
  logic [7:0]  lo_b, hi_b, pclamp;
  logic [11:0] us_clamp;
  logic [15:0] t_sel;
  logic [11:0] pw;
  logic [12:0] diff_s;
  logic [12:0] step_s;
  logic [16:0] rem_sh;

  always_comb begin
    count_eff = count_reg_q;
    if (count_reg_q == 4'd0) begin
      count_eff = 4'd1;
    end else if (count_reg_q > 4'(Channels)) begin
      count_eff = 4'(Channels);
    end
  end

  assign lo_b = lower_q[8*ch_q +: 8];
  assign hi_b = upper_q[8*ch_q +: 8];
  always_comb begin
    pclamp = pos_q;
    if (pclamp < lo_b) pclamp = lo_b;
    if (pclamp > hi_b) pclamp = hi_b;
    us_clamp = 12'(us_q);
    if (us_q < 16'(PulseMinUs)) us_clamp = PulseMinUs;
    else if (us_q > 16'(PulseMaxUs)) us_clamp = PulseMaxUs;
  end

  assign t_sel = cmd_i.sel[2] ? thi_q[16*cmd_i.sel[1:0] +: 16]
                              : tlo_q[16*cmd_i.sel[1:0] +: 16];
  assign diff_s = 13'(tgt_q[cmd_i.sel]) - 13'(st_q[cmd_i.sel]);
  assign rem_sh = {rem_q[15:0], acc_q[27]};
  assign step_s = neg_q ? 13'(-quo_q[12:0]) : quo_q[12:0];

  always_comb begin
    pw = cur_q[slot_q];
    if (pw < PulseMinUs) pw = PulseMinUs;
    if (pw > PulseMaxUs) pw = PulseMaxUs;
  end

  assign sts_o.op        = op_q;
  assign sts_o.ramp_done = done_q;
  assign sts_o.ramp_skip = (cur_q[cmd_i.sel] == tgt_q[cmd_i.sel]) || (t_sel == 16'd0)
                           || (el_q[cmd_i.sel] >= t_sel);
  assign sts_o.count     = count_eff;

  // Hold configuration, item and channel state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_reg_q <= 4'd8;
      lower_q <= '0;
      upper_q <= '1;
      tlo_q <= '0;
      thi_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        cur_q[i] <= MapLowUs;
        tgt_q[i] <= MapLowUs;
        st_q[i]  <= MapLowUs;
        el_q[i]  <= '0;
      end
      slot_q <= '0;
      phase_q <= 1'b0;
      strobe_o <= 1'b0;
      pin_channel_o <= '0;
      pin_level_o <= 1'b0;
      delay_us_o <= '0;
      op_q <= '0;
      ch_q <= '0;
      pos_q <= '0;
      us_q <= '0;
      acc_q <= '0;
      mul_q <= '0;
      div_q <= '0;
      mag_q <= '0;
      neg_q <= 1'b0;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      done_q <= 1'b0;
      phase_div_q <= 1'b0;
    end else begin
      strobe_o <= 1'b0;
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegCount:   count_reg_q <= cfg_data_i[3:0];
          RegLower:   lower_q <= cfg_data_i;
          RegUpper:   upper_q <= cfg_data_i;
          RegTimesLo: tlo_q <= cfg_data_i;
          RegTimesHi: thi_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load_item) begin
        op_q <= op_i;
        ch_q <= channel_i;
        pos_q <= position_i;
        us_q <= pulse_us_i;
      end
      // Reload one channel per cycle from its lower limit.
      if (cmd_i.reload_ch) begin
        cur_q[cmd_i.sel] <= pos_to_us(lower_q[8*cmd_i.sel +: 8]);
        tgt_q[cmd_i.sel] <= pos_to_us(lower_q[8*cmd_i.sel +: 8]);
        st_q[cmd_i.sel]  <= pos_to_us(lower_q[8*cmd_i.sel +: 8]);
        el_q[cmd_i.sel]  <= '0;
      end
      // Start a ramp on an active channel; drop requests for inactive ones.
      if ((cmd_i.set_pos || cmd_i.set_us) && (4'(ch_q) < count_eff)) begin
        tgt_q[ch_q] <= cmd_i.set_pos ? pos_to_us(pclamp) : us_clamp;
        st_q[ch_q]  <= cur_q[ch_q];
        el_q[ch_q]  <= '0;
      end
      if (cmd_i.tick_inc) begin
        for (int i = 0; i < Channels; i++) begin
          if (el_q[i] != 16'hFFFF) el_q[i] <= el_q[i] + 16'd1;
        end
      end
      // Serial ramp: 16 shift-add steps, then 28 divide steps.
      if (cmd_i.ramp_load) begin
        neg_q <= diff_s[12];
        mag_q <= diff_s[12] ? 13'(-diff_s) : diff_s;
        mul_q <= el_q[cmd_i.sel];
        div_q <= t_sel;
        acc_q <= '0;
        cnt_q <= '0;
        phase_div_q <= 1'b0;
        rem_q <= '0;
      end else if (cmd_i.ramp_step) begin
        if (!phase_div_q) begin
          acc_q <= (acc_q << 1) + (mul_q[15] ? 28'(mag_q) : 28'd0);
          mul_q <= mul_q << 1;
          if (cnt_q == 6'd15) begin
            cnt_q <= '0;
            phase_div_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end else begin
          if (rem_sh >= 17'(div_q)) begin
            rem_q <= rem_sh - 17'(div_q);
            quo_q <= {quo_q[26:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[26:0], 1'b0};
          end
          acc_q <= acc_q << 1;
          if (cnt_q == 6'd27) begin
            done_q <= 1'b1;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
      end
      if (cmd_i.ramp_write) begin
        if (cur_q[cmd_i.sel] != tgt_q[cmd_i.sel]) begin
          if (sts_o.ramp_skip) begin
            cur_q[cmd_i.sel] <= tgt_q[cmd_i.sel];
          end else begin
            cur_q[cmd_i.sel] <= 12'(st_q[cmd_i.sel] + 12'(step_s));
          end
        end
      end
      // Emit slot result and advance the phase.
      if (cmd_i.slot_emit) begin
        strobe_o <= 1'b1;
        pin_channel_o <= slot_q;
        if (phase_q) begin
          pin_level_o <= 1'b0;
          delay_us_o <= SlotUs - pw;
          phase_q <= 1'b0;
          if (4'(slot_q) + 4'd1 >= count_eff) slot_q <= '0;
          else slot_q <= slot_q + 3'd1;
        end else begin
          pin_level_o <= 1'b1;
          delay_us_o <= pw;
          phase_q <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (delay_us_o >= 12'd100 && delay_us_o <= PulseMaxUs))
    else $error("delay out of range");
  a_phase_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.slot_emit |=> (phase_q != $past(phase_q)))
    else $error("phase did not toggle");
  a_level_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (pin_level_o == phase_q))
    else $error("level and phase disagree");
`endif

endmodule
`default_nettype wire

FILE: rtl/msprc_ctrl.sv
// ---------------------------------------------------------------------------
// msprc_ctrl
// Sequencer: accepts items, walks channels on tick and on limit reload.
// ---------------------------------------------------------------------------
`default_nettype none
module msprc_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic                   reload_i,
  input  wire msprc_pkg::msprc_sts_t  sts_i,
  output msprc_pkg::msprc_cmd_t       cmd_o
);
  import msprc_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecode, StReload, StTickSel, StRampRun, StRampWr
  } state_e;

  state_e          state_q;
  logic [ChW-1:0]  sel_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = sel_q;
    cmd_o.load_item = (state_q == StIdle) && start_i && !reload_i;
    unique case (state_q)
      StIdle: ;
      StDecode: begin
        unique case (sts_i.op)
          OpSetPos:  cmd_o.set_pos = 1'b1;
          OpSetUs:   cmd_o.set_us = 1'b1;
          OpTick:    cmd_o.tick_inc = 1'b1;
          OpSlotExp: cmd_o.slot_emit = 1'b1;
          default: ;
        endcase
      end
      StReload:  cmd_o.reload_ch = 1'b1;
      StTickSel: begin
        if (sts_i.ramp_skip) cmd_o.ramp_write = 1'b1;
        else cmd_o.ramp_load = 1'b1;
      end
      StRampRun: cmd_o.ramp_step = !sts_i.ramp_done;
      StRampWr:  cmd_o.ramp_write = 1'b1;
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle) || reload_i;

  // Hold state and the channel index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          sel_q <= '0;
          if (reload_i) state_q <= StReload;
          else if (start_i) state_q <= StDecode;
        end
        StDecode: begin
          if (sts_i.op == OpTick) state_q <= StTickSel;
          else state_q <= StIdle;
        end
        StReload: begin
          sel_q <= sel_q + 3'd1;
          if (sel_q == 3'(Channels - 1)) state_q <= StIdle;
        end
        StTickSel: begin
          if (sts_i.ramp_skip) begin
            if (4'(sel_q) + 4'd1 >= sts_i.count) state_q <= StIdle;
            sel_q <= sel_q + 3'd1;
          end else begin
            state_q <= StRampRun;
          end
        end
        StRampRun: if (sts_i.ramp_done) state_q <= StRampWr;
        StRampWr: begin
          sel_q <= sel_q + 3'd1;
          if (4'(sel_q) + 4'd1 >= sts_i.count) state_q <= StIdle;
          else state_q <= StTickSel;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_ramp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !(cmd_o.ramp_step || cmd_o.ramp_write))
    else $error("ramp command while idle");
  a_decode_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDecode) |=> (state_q != StDecode))
    else $error("decode repeated");
  a_sel_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRampWr) |-> (4'(sel_q) < sts_i.count))
    else $error("ramp on inactive channel");
`endif

endmodule
`default_nettype wire

FILE: rtl/multi_servo_pulse_ramp_controller.sv
// A slot expiry is decoded in StDecode and gives its result through the registered strobe; set ops apply in StDecode.
// A tick walks each active channel in turn; a ramping channel runs the
// serial multiply (16 steps) and divide (28 steps) before its write.
// A lower_limits write starts a reload sweep over all eight channels; busy stays high meanwhile.
// Results appear for one cycle on result_strobe_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) restores all registers and channel widths of 1000 us.
// ---------------------------------------------------------------------------
// multi_servo_pulse_ramp_controller
// Eight-slot servo pulse sequencer with timed linear ramps.
// ---------------------------------------------------------------------------
`default_nettype none
module multi_servo_pulse_ramp_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [7:0]  position_i,
  input  wire logic [15:0] pulse_us_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             result_strobe_o,
  output logic [2:0]       pin_channel_o,
  output logic             pin_level_o,
  output logic [11:0]      delay_us_o
);
  import msprc_pkg::*;

  msprc_cmd_t cmd;
  msprc_sts_t sts;
  logic       cfg_we;
  logic       reload_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  // Hold a pending reload request until the sweep starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= 1'b0;
    end else begin
      if (cfg_we && cfg_index_i == RegLower) reload_q <= 1'b1;
      else if (cmd.reload_ch) reload_q <= 1'b0;
    end
  end

  msprc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .reload_i(reload_q),
    .sts_i(sts), .cmd_o(cmd)
  );

  msprc_datapath u_dp (
    .clk_i, .rst_ni, .op_i, .channel_i, .position_i, .pulse_us_i,
    .cfg_we_i(cfg_we), .cfg_index_i, .cfg_data_i, .cmd_i(cmd), .sts_o(sts),
    .strobe_o(result_strobe_o), .pin_channel_o, .pin_level_o, .delay_us_o
  );

endmodule
`default_nettype wire

FILE: tb/multi_servo_pulse_ramp_controller_test.sv
// ---------------------------------------------------------------------------
// multi_servo_pulse_ramp_controller_test
// Drives set, tick and slot-expiry items through the servo sequencer under
// several register settings and random gaps, predicts each slot result with
// a cycle-free model of the channel ramps, and compares every strobed result.
// ---------------------------------------------------------------------------
module multi_servo_pulse_ramp_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import msprc_pkg::*;

  localparam logic [2:0] RegUnused  = 3'd5;
  localparam int         SettleCyc  = 500;
  localparam int         StallLimit = 6000;

  typedef struct packed {
    logic [2:0]  chan;
    logic        level;
    logic [11:0] delay;
  } pin_event_t;

  // Ramp model of all channels plus the queue of expected pin events.
  class servo_scoreboard;
    logic [11:0] cur_w[8], tgt_w[8], beg_w[8];
    logic [15:0] elapsed[8];
    logic [2:0]  slot;
    logic        high_phase;
    logic [3:0]  count_reg;
    logic [63:0] lower, upper, times_lo, times_hi;
    pin_event_t  pin_events[$];
    int          errors;

    function void reset();
      count_reg = 4'd8; lower = '0; upper = '1; times_lo = '0; times_hi = '0;
      slot = '0; high_phase = 1'b0; errors = 0;
      reload();
    endfunction

    function logic [11:0] map_pos(logic [7:0] p);
      return 12'(1000 + (1000 * int'(p)) / 255);
    endfunction

    function int active();
      if (count_reg == 0) return 1;
      if (count_reg > 8) return 8;
      return count_reg;
    endfunction

    function void reload();
      for (int i = 0; i < 8; i++) begin
        cur_w[i] = map_pos(lower[i*8 +: 8]);
        tgt_w[i] = cur_w[i];
        beg_w[i] = cur_w[i];
        elapsed[i] = '0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        RegCount:   count_reg = data[3:0];
        RegLower:   begin lower = data; reload(); end
        RegUpper:   upper = data;
        RegTimesLo: times_lo = data;
        RegTimesHi: times_hi = data;
        default:    ;
      endcase
    endfunction

    // Apply one accepted item; queue a pin event for slot expiries.
    function void note_item(logic [1:0] op, logic [2:0] ch, logic [7:0] pos,
                            logic [15:0] us);
      int lo, hi, t, step, pw, s;
      pin_event_t ev;
      case (op)
        OpSetPos, OpSetUs: begin
          if (ch < active()) begin
            tgt_w[ch] = (op == OpSetUs) ? 12'((us < 500) ? 500 : (us > 2400) ? 2400 : us)
                                        : 12'(0);
            if (op == OpSetPos) begin
              lo = lower[ch*8 +: 8];
              hi = upper[ch*8 +: 8];
              if (pos < lo) pos = 8'(lo);
              if (pos > hi) pos = 8'(hi);
              tgt_w[ch] = map_pos(pos);
            end
            beg_w[ch] = cur_w[ch];
            elapsed[ch] = '0;
          end
        end
        OpTick: begin
          for (int i = 0; i < 8; i++)
            if (elapsed[i] != 16'hFFFF) elapsed[i]++;
          for (int i = 0; i < active(); i++) begin
            t = (i < 4) ? times_lo[i*16 +: 16] : times_hi[(i-4)*16 +: 16];
            if (cur_w[i] == tgt_w[i]) continue;
            if (t == 0 || int'(elapsed[i]) >= t) cur_w[i] = tgt_w[i];
            else begin
              step = ((int'(tgt_w[i]) - int'(beg_w[i])) * int'(elapsed[i])) / t;
              cur_w[i] = 12'(int'(beg_w[i]) + step);
            end
          end
        end
        default: begin
          s = slot;
          pw = cur_w[s];
          if (pw < 500) pw = 500;
          if (pw > 2400) pw = 2400;
          ev.chan = 3'(s);
          if (high_phase) begin
            ev.level = 1'b0;
            ev.delay = 12'(2500 - pw);
            high_phase = 1'b0;
            s++;
            if (s >= active()) s = 0;
            slot = 3'(s);
          end else begin
            ev.level = 1'b1;
            ev.delay = 12'(pw);
            high_phase = 1'b1;
          end
          pin_events.push_back(ev);
        end
      endcase
    endfunction

    function void check_result(pin_event_t got);
      pin_event_t exp_ev;
      if (pin_events.size() == 0) begin
        $error("unexpected pin event ch=%0d level=%0d delay=%0d",
               got.chan, got.level, got.delay);
        errors++;
        return;
      end
      exp_ev = pin_events.pop_front();
      if (got.chan != exp_ev.chan) begin
        $error("pin_channel expected %0d actual %0d", exp_ev.chan, got.chan);
        errors++;
      end
      if (got.level != exp_ev.level) begin
        $error("pin_level expected %0d actual %0d", exp_ev.level, got.level);
        errors++;
      end
      if (got.delay != exp_ev.delay) begin
        $error("delay_us expected %0d actual %0d", exp_ev.delay, got.delay);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op_i = OpTick;
  logic [2:0]  channel_i = '0;
  logic [7:0]  position_i = '0;
  logic [15:0] pulse_us_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = RegCount;
  logic [63:0] cfg_data_i = '0;
  logic        result_strobe_o;
  logic [2:0]  pin_channel_o;
  logic        pin_level_o;
  logic [11:0] delay_us_o;

  servo_scoreboard sb;
  int  stall_cycles = 0;
  bit  any_handshake;
  bit  no_gaps;

  multi_servo_pulse_ramp_controller u_dut (.*);

  always #4 clk_i = ~clk_i;

  // Check each strobed result against the oldest pin event.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o)
      sb.check_result('{pin_channel_o, pin_level_o, delay_us_o});
  end

  // Abort when nothing moves for too long.
  always @(posedge clk_i) begin
    if (any_handshake || result_strobe_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    any_handshake <= 1'b0;
    if (stall_cycles > StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic idle_gap();
    int sel, n;
    sel = $urandom_range(99);
    n = no_gaps ? 0 : (sel < 65) ? 0 : (sel < 93) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_item(logic [1:0] op, logic [2:0] ch, logic [7:0] pos,
                           logic [15:0] us);
    start      <= 1'b1;
    op_i       <= op;
    channel_i  <= ch;
    position_i <= pos;
    pulse_us_i <= us;
    do @(posedge clk_i); while (busy);
    any_handshake = 1'b1;
    sb.note_item(op, ch, pos, us);
    idle_gap();
  endtask

  // Drain outstanding events and let any tick or reload finish.
  task automatic wait_quiet();
    start <= 1'b0;
    while (sb.pin_events.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) begin
      any_handshake = 1'b1;
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    any_handshake = 1'b1;
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_item();
    int sel;
    logic [15:0] us;
    sel = $urandom_range(99);
    us = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(400, 2500));
    if (sel < 40)      send_item(OpSlotExp, 3'($urandom), 8'($urandom), 16'($urandom));
    else if (sel < 72) send_item(OpTick, 3'($urandom), 8'($urandom), 16'($urandom));
    else if (sel < 86) send_item(OpSetPos, 3'($urandom), 8'($urandom), us);
    else               send_item(OpSetUs, 3'($urandom), 8'($urandom), us);
  endtask

  initial begin
    logic [63:0] t64;
    sb = new();
    sb.reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every op, clamps, inactive channel, instant ramps.
    no_gaps = 1'b0;
    send_item(OpSlotExp, 3'd0, 8'd0, 16'd0);
    send_item(OpSlotExp, 3'd0, 8'd0, 16'd0);
    send_item(OpSetPos, 3'd1, 8'd255, 16'hFFFF);
    send_item(OpSetUs, 3'd0, 8'd0, 16'd0);
    send_item(OpSetUs, 3'd2, 8'd0, 16'hFFFF);
    send_item(OpSetUs, 3'd3, 8'd0, 16'd499);
    send_item(OpSetUs, 3'd4, 8'd0, 16'd2401);
    send_item(OpTick, 3'd7, 8'hFF, 16'hFFFF);
    repeat (8) send_item(OpSlotExp, 3'd7, 8'hFF, 16'hFFFF);
    write_reg(RegCount, 64'd2);
    send_item(OpSetUs, 3'd5, 8'd0, 16'd2000);
    send_item(OpSetPos, 3'd7, 8'd128, 16'd0);
    repeat (4) send_item(OpSlotExp, 3'd0, 8'd0, 16'd0);
    write_reg(RegUnused, rand64());
    write_reg(RegCount, 64'd0);
    repeat (3) send_item(OpSlotExp, 3'd0, 8'd0, 16'd0);

    // Long ramp on a channel parked beyond the active count.
    write_reg(RegCount, 64'd8);
    write_reg(RegTimesHi, 64'hFFFF << 16);
    send_item(OpSetUs, 3'd5, 8'd0, 16'd2300);
    write_reg(RegCount, 64'd1);
    no_gaps = 1'b1;
    repeat (30) send_item(OpTick, 3'd0, 8'd0, 16'd0);
    write_reg(RegCount, 64'd8);
    send_item(OpTick, 3'd0, 8'd0, 16'd0);
    repeat (12) send_item(OpSlotExp, 3'd0, 8'd0, 16'd0);

    // Random phases under varied settings.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: t64 = '0;
        1: begin
          t64 = '0;
          for (int k = 0; k < 4; k++) t64[k*16 +: 16] = 16'($urandom_range(1, 25));
        end
        default: t64 = rand64();
      endcase
      write_reg(RegCount, (ph == 0) ? 64'd8 : (ph == 4) ? 64'd15 :
                          (ph == 7) ? 64'd1 : 64'($urandom_range(0, 15)));
      write_reg(RegTimesLo, t64);
      write_reg(RegTimesHi, (ph == 8) ? 64'hFFFF_FFFF_FFFF_FFFF :
                            (ph % 3 == 2) ? rand64() : t64);
      if (ph == 8) write_reg(RegTimesLo, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(RegUpper, (ph == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64());
      write_reg(RegLower, (ph == 0) ? 64'd0 : (ph == 5) ? 64'hFFFF_FFFF_FFFF_FFFF
                                    : rand64() & 64'h7F7F_7F7F_7F7F_7F7F);
      no_gaps = (ph == 3);
      repeat (200) random_item();
    end

    wait_quiet();
    if (sb.errors == 0 && sb.pin_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
